// File: hw/rtl/mm8_pkg.sv
// Shared types and constants for the 8-bit single-cycle core.
package mm8_pkg;

	localparam int InstrWidth = 16;
	localparam int DataWidth  = 8;
	localparam int PcWidth    = 8;
	localparam int RegCount   = 8;
	localparam int RegIdxWidth = 3;
	localparam int InWidth    = 32;
	localparam int OutWidth   = 40;

	localparam logic KIND_EXEC    = 1'b0;
	localparam logic KIND_PRELOAD = 1'b1;

	typedef enum logic [3:0] {
		OP_RTYPE = 4'd0,
		OP_J     = 4'd2,
		OP_ADDI  = 4'd4,
		OP_BEQ   = 4'd8,
		OP_LW    = 4'd11,
		OP_SW    = 4'd15
	} opcode_t;

	typedef enum logic [2:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd2,
		FN_AND = 3'd4,
		FN_OR  = 3'd5
	} funct_t;

	typedef struct packed {
		logic                   illegal;
		logic                   branch_taken;
		logic                   overflow;
		logic [DataWidth-1:0]   mem_value;
		logic [7:0]             mem_address;
		logic                   mem_write;
		logic [DataWidth-1:0]   reg_value;
		logic [RegIdxWidth-1:0] reg_index;
		logic                   reg_write;
		logic [PcWidth-1:0]     next_pc;
	} result_t;

endpackage

// File: hw/rtl/mini_mips8_single_cycle_core.sv
// Top level of the 8-bit single-cycle core: decode, execute, data memory and result stage.
//
//  Channel  Direction  Fields
//  s_*      in         tuser: kind; tdata: instruction, preload_address, preload_value
//  m_*      out        tdata: next_pc, reg_write, reg_index, reg_value, mem_write,
//                             mem_address, mem_value, overflow, branch_taken, illegal
//
// One item is accepted every cycle unless stalled; the input register feeds the result register.
// An item is executed combinationally from the input register; a load's data comes from
// the data memory's registered read port in the result stage and is forwarded back.
// Reset clears the pc, the registers and one valid bit per data memory entry at once.
// Input transfers stall only while the input register is full and the result is held.
module mini_mips8_single_cycle_core #(
	parameter int DATA_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // instruction[15:0], preload_address[23:16], preload_value[31:24]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // next_pc, reg_write, reg_index, reg_value, mem_write,
	                              // mem_address, mem_value, overflow, branch_taken, illegal
);

	localparam int AW = $clog2(DATA_DEPTH);

	logic [AW-1:0] amod_tbl [256];
	logic [AW-1:0] imod_tbl [64];
	logic [AW-1:0] pmod_tbl [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_amod
		localparam int AMod = (((gi >= 128) ? gi - 256 : gi) % DATA_DEPTH + DATA_DEPTH)
			% DATA_DEPTH;
		localparam int PMod = gi % DATA_DEPTH;
		assign amod_tbl[gi] = AW'(AMod);
		assign pmod_tbl[gi] = AW'(PMod);
	end

	for (genvar gi = 0; gi < 64; gi++) begin : g_imod
		localparam int IMod = (((gi >= 32) ? gi - 64 : gi) % DATA_DEPTH + DATA_DEPTH)
			% DATA_DEPTH;
		assign imod_tbl[gi] = AW'(IMod);
	end

	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] instr_s1;
	logic [7:0]  paddr_s1;
	logic [7:0]  pval_s1;

	logic                valid_s2;
	mm8_pkg::result_t    res_s2;
	logic                load_s2;

	logic [7:0]          pc_q;
	logic [7:0]          rf_q [mm8_pkg::RegCount];
	logic [DATA_DEPTH-1:0] valid_q;
	logic                ld_pend_q;
	logic [2:0]          ld_idx_q;
	logic                ld_hit_q;

	logic                s1_adv;
	logic [7:0]          ram_rdata;
	logic [7:0]          ld_data;

	logic [3:0]  op;
	logic [2:0]  rs;
	logic [2:0]  rt;
	logic [2:0]  rd;
	logic [2:0]  fn;
	logic [5:0]  imm;
	logic [7:0]  a_val;
	logic [7:0]  b_val;
	logic [8:0]  sum_ab;
	logic [8:0]  dif_ab;
	logic [8:0]  sum_ai;
	logic [AW:0] addr_sum;
	logic [AW-1:0] mem_addr;

	mm8_pkg::result_t res_d;
	logic             load_d;
	logic             rf_we;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;

	assign s1_adv   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign ld_data  = ld_hit_q ? ram_rdata : 8'd0;

	assign op  = instr_s1[15:12];
	assign rs  = instr_s1[11:9];
	assign rt  = instr_s1[8:6];
	assign rd  = instr_s1[5:3];
	assign fn  = instr_s1[2:0];
	assign imm = instr_s1[5:0];

	assign a_val = (ld_pend_q && ld_idx_q == rs) ? ld_data : rf_q[rs];
	assign b_val = (ld_pend_q && ld_idx_q == rt) ? ld_data : rf_q[rt];

	assign sum_ab = {a_val[7], a_val} + {b_val[7], b_val};
	assign dif_ab = {a_val[7], a_val} - {b_val[7], b_val};
	assign sum_ai = {a_val[7], a_val} + {{3{imm[5]}}, imm};

	assign addr_sum = {1'b0, amod_tbl[a_val]} + {1'b0, imod_tbl[imm]};
	assign mem_addr = (addr_sum >= (AW + 1)'(DATA_DEPTH))
		? AW'(addr_sum - (AW + 1)'(DATA_DEPTH)) : AW'(addr_sum);

	always_comb begin
		res_d         = '0;
		res_d.next_pc = pc_q;
		load_d        = 1'b0;
		rf_we         = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = mem_addr;
		ram_wdata     = b_val;
		if (kind_s1 == mm8_pkg::KIND_PRELOAD) begin
			ram_we            = 1'b1;
			ram_waddr         = pmod_tbl[paddr_s1];
			ram_wdata         = pval_s1;
			res_d.mem_write   = 1'b1;
			res_d.mem_address = 8'(pmod_tbl[paddr_s1]);
			res_d.mem_value   = pval_s1;
		end else begin
			case (op)
				mm8_pkg::OP_RTYPE: begin
					res_d.reg_write = 1'b1;
					res_d.reg_index = rd;
					res_d.next_pc   = pc_q + 8'd1;
					rf_we           = 1'b1;
					case (fn)
						mm8_pkg::FN_ADD: begin
							res_d.reg_value = sum_ab[7:0];
							res_d.overflow  = sum_ab[8] ^ sum_ab[7];
						end
						mm8_pkg::FN_SUB: begin
							res_d.reg_value = dif_ab[7:0];
							res_d.overflow  = dif_ab[8] ^ dif_ab[7];
						end
						mm8_pkg::FN_AND: res_d.reg_value = a_val & b_val;
						mm8_pkg::FN_OR:  res_d.reg_value = a_val | b_val;
						default: begin
							res_d         = '0;
							res_d.next_pc = pc_q;
							res_d.illegal = 1'b1;
							rf_we         = 1'b0;
						end
					endcase
				end
				mm8_pkg::OP_J: begin
					res_d.next_pc      = {1'b0, instr_s1[6:0]} + 8'd1;
					res_d.branch_taken = 1'b1;
				end
				mm8_pkg::OP_ADDI: begin
					rf_we           = 1'b1;
					res_d.reg_write = 1'b1;
					res_d.reg_index = rt;
					res_d.reg_value = sum_ai[7:0];
					res_d.overflow  = sum_ai[8] ^ sum_ai[7];
					res_d.next_pc   = pc_q + 8'd1;
				end
				mm8_pkg::OP_BEQ: begin
					if (a_val == b_val) begin
						res_d.next_pc      = pc_q + {{2{imm[5]}}, imm} + 8'd1;
						res_d.branch_taken = 1'b1;
					end else begin
						res_d.next_pc = pc_q + 8'd1;
					end
				end
				mm8_pkg::OP_LW: begin
					load_d            = 1'b1;
					res_d.reg_write   = 1'b1;
					res_d.reg_index   = rt;
					res_d.overflow    = sum_ai[8] ^ sum_ai[7];
					res_d.mem_address = 8'(mem_addr);
					res_d.next_pc     = pc_q + 8'd1;
				end
				mm8_pkg::OP_SW: begin
					ram_we            = 1'b1;
					res_d.mem_write   = 1'b1;
					res_d.mem_address = 8'(mem_addr);
					res_d.mem_value   = b_val;
					res_d.overflow    = sum_ai[8] ^ sum_ai[7];
					res_d.next_pc     = pc_q + 8'd1;
				end
				default: res_d.illegal = 1'b1;
			endcase
		end
	end

	mm8_ram #(
		.WIDTH (8),
		.DEPTH (DATA_DEPTH)
	) u_dmem (
		.clk   (clk),
		.we    (s1_adv && ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (s1_adv && load_d),
		.raddr (mem_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			pc_q      <= '0;
			valid_q   <= '0;
			ld_pend_q <= 1'b0;
			for (int i = 0; i < mm8_pkg::RegCount; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (ld_pend_q && !(s1_adv && rf_we && res_d.reg_index == ld_idx_q)) begin
				rf_q[ld_idx_q] <= ld_data;
			end
			ld_pend_q <= s1_adv && load_d;
			if (s1_adv) begin
				pc_q <= res_d.next_pc;
				if (rf_we) begin
					rf_q[res_d.reg_index] <= res_d.reg_value;
				end
				if (ram_we) begin
					valid_q[ram_waddr] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= s_tuser;
			instr_s1 <= s_tdata[15:0];
			paddr_s1 <= s_tdata[23:16];
			pval_s1  <= s_tdata[31:24];
		end
		if (s1_adv) begin
			res_s2   <= res_d;
			load_s2  <= load_d;
			ld_idx_q <= rt;
			ld_hit_q <= valid_q[mem_addr];
		end
	end

	always_comb begin
		m_tdata = res_s2;
		if (load_s2) begin
			m_tdata[19:12] = ld_data;
			m_tdata[36:29] = ld_data;
		end
	end

	assign m_tvalid = valid_s2;

endmodule

// File: hw/rtl/mm8_ram.sv
// Generic single-port-write, registered-read RAM.
module mm8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: tb/mini_mips8_single_cycle_core_test.sv
// Self-checking testbench for the 8-bit single-cycle core: a directed table, then random programs.
`timescale 1ns / 1ps

module mini_mips8_single_cycle_core_test;

	localparam int CycleLimit = 400000;
	localparam int LongHold   = 80;

	typedef struct {
		logic             kind;
		logic [15:0]      word;
		logic [7:0]       paddr;
		logic [7:0]       pval;
		bit               typed;
		mm8_pkg::result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = mm8_pkg::KIND_EXEC;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	logic [7:0]       pc_shadow;
	logic [7:0]       regs_shadow [mm8_pkg::RegCount];
	logic [7:0]       mem_shadow [256];
	mm8_pkg::result_t pending_retires [$];
	stim_row_t        directed_rows [$];
	int               mismatches     = 0;
	int               cycles         = 0;
	bit               sender_idle_en = 1'b1;
	bit               sink_idle_en   = 1'b1;
	bit               hold_request   = 1'b0;

	mini_mips8_single_cycle_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] rtype(logic [2:0] fn, logic [2:0] rs, logic [2:0] rt,
			logic [2:0] rd);
		return {mm8_pkg::OP_RTYPE, rs, rt, rd, fn};
	endfunction

	function automatic logic [15:0] itype(logic [3:0] op, logic [2:0] rs, logic [2:0] rt,
			logic [5:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic mm8_pkg::result_t retired(logic [7:0] pc, logic rw, logic [2:0] ri,
			logic [7:0] rv, logic mw, logic [7:0] ma, logic [7:0] mv, logic ov, logic bt,
			logic il);
		mm8_pkg::result_t r;
		r.next_pc = pc;
		r.reg_write = rw;
		r.reg_index = ri;
		r.reg_value = rv;
		r.mem_write = mw;
		r.mem_address = ma;
		r.mem_value = mv;
		r.overflow = ov;
		r.branch_taken = bt;
		r.illegal = il;
		return r;
	endfunction

	function automatic stim_row_t stim_row(logic kind, logic [15:0] word, logic [7:0] paddr,
			logic [7:0] pval, bit typed, mm8_pkg::result_t want);
		stim_row_t row;
		row.kind = kind;
		row.word = word;
		row.paddr = paddr;
		row.pval = pval;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	// Retires one item against the shadow state and returns what the core should report.
	function automatic mm8_pkg::result_t retire_item(logic kind, logic [15:0] word,
			logic [7:0] paddr, logic [7:0] pval);
		mm8_pkg::result_t r;
		logic [2:0] rs;
		logic [2:0] rt;
		logic [2:0] rd;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] imm8;
		logic [7:0] next;
		logic [8:0] sum;
		r = '0;
		next = pc_shadow;
		if (kind == mm8_pkg::KIND_PRELOAD) begin
			mem_shadow[paddr] = pval;
			r.mem_write = 1'b1;
			r.mem_address = paddr;
			r.mem_value = pval;
		end else begin
			rs = word[11:9];
			rt = word[8:6];
			rd = word[5:3];
			a = regs_shadow[rs];
			b = regs_shadow[rt];
			imm8 = {{2{word[5]}}, word[5:0]};
			// Nine bits hold every true sum, so bit 8 differing from bit 7 means overflow
			// and the low byte is the address reduced modulo the memory depth.
			sum = {a[7], a} + {imm8[7], imm8};
			case (word[15:12])
				mm8_pkg::OP_RTYPE: begin
					case (word[2:0])
						mm8_pkg::FN_ADD: sum = {a[7], a} + {b[7], b};
						mm8_pkg::FN_SUB: sum = {a[7], a} - {b[7], b};
						mm8_pkg::FN_AND: sum = {1'b0, a & b};
						mm8_pkg::FN_OR: sum = {1'b0, a | b};
						default: r.illegal = 1'b1;
					endcase
					if (!r.illegal) begin
						r.overflow = (word[2:0] == mm8_pkg::FN_ADD ||
							word[2:0] == mm8_pkg::FN_SUB) && (sum[8] != sum[7]);
						regs_shadow[rd] = sum[7:0];
						r.reg_write = 1'b1;
						r.reg_index = rd;
						r.reg_value = sum[7:0];
						next = pc_shadow + 8'd1;
					end
				end
				mm8_pkg::OP_J: begin
					next = {1'b0, word[6:0]} + 8'd1;
					r.branch_taken = 1'b1;
				end
				mm8_pkg::OP_ADDI: begin
					r.overflow = sum[8] != sum[7];
					regs_shadow[rt] = sum[7:0];
					r.reg_write = 1'b1;
					r.reg_index = rt;
					r.reg_value = sum[7:0];
					next = pc_shadow + 8'd1;
				end
				mm8_pkg::OP_BEQ: begin
					if (a == b) begin
						next = pc_shadow + imm8 + 8'd1;
						r.branch_taken = 1'b1;
					end else begin
						next = pc_shadow + 8'd1;
					end
				end
				mm8_pkg::OP_LW: begin
					r.overflow = sum[8] != sum[7];
					regs_shadow[rt] = mem_shadow[sum[7:0]];
					r.reg_write = 1'b1;
					r.reg_index = rt;
					r.reg_value = mem_shadow[sum[7:0]];
					r.mem_address = sum[7:0];
					r.mem_value = mem_shadow[sum[7:0]];
					next = pc_shadow + 8'd1;
				end
				mm8_pkg::OP_SW: begin
					r.overflow = sum[8] != sum[7];
					mem_shadow[sum[7:0]] = b;
					r.mem_write = 1'b1;
					r.mem_address = sum[7:0];
					r.mem_value = b;
					next = pc_shadow + 8'd1;
				end
				default: r.illegal = 1'b1;
			endcase
			pc_shadow = next;
		end
		r.next_pc = pc_shadow;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic offer(input logic kind, input logic [15:0] word, input logic [7:0] paddr,
			input logic [7:0] pval, input bit typed, input mm8_pkg::result_t typed_res);
		mm8_pkg::result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {pval, paddr, word};
		do @(posedge clk); while (!s_tready);
		predicted = retire_item(kind, word, paddr, pval);
		pending_retires.push_back(typed ? typed_res : predicted);
		if (sender_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom();
			s_tuser <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_retires.size() != 0);
	endtask

	// Mostly well-formed instructions with random operands, some preloads and some noise.
	task automatic send_random(input int count);
		logic [15:0] word;
		int          pick;
		repeat (count) begin
			word = 16'($urandom());
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				offer(mm8_pkg::KIND_PRELOAD, word, 8'($urandom()), 8'($urandom()), 1'b0, '0);
			end else begin
				if (pick < 40) begin
					word[15:12] = mm8_pkg::OP_RTYPE;
					if ($urandom_range(0, 7) != 0) begin
						case ($urandom_range(0, 3))
							0: word[2:0] = mm8_pkg::FN_ADD;
							1: word[2:0] = mm8_pkg::FN_SUB;
							2: word[2:0] = mm8_pkg::FN_AND;
							default: word[2:0] = mm8_pkg::FN_OR;
						endcase
					end
				end else if (pick < 58) begin
					word[15:12] = mm8_pkg::OP_ADDI;
				end else if (pick < 70) begin
					word[15:12] = mm8_pkg::OP_LW;
				end else if (pick < 82) begin
					word[15:12] = mm8_pkg::OP_SW;
				end else if (pick < 91) begin
					word[15:12] = mm8_pkg::OP_BEQ;
					if ($urandom_range(0, 1) == 0) word[8:6] = word[11:9];
				end else if (pick < 96) begin
					word[15:12] = mm8_pkg::OP_J;
				end
				offer(mm8_pkg::KIND_EXEC, word, 8'($urandom()), 8'($urandom()), 1'b0, '0);
			end
		end
	endtask

	initial begin
		pc_shadow = '0;
		foreach (regs_shadow[i]) regs_shadow[i] = '0;
		foreach (mem_shadow[i]) mem_shadow[i] = '0;

		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_LW, 3'd0, 3'd2, 6'd0), 8'h00, 8'h00, 1'b1,
			retired(8'd1, 1'b1, 3'd2, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_PRELOAD, 16'hFFFF, 8'hFF, 8'h80, 1'b1,
			retired(8'd1, 1'b0, 3'd0, 8'h00, 1'b1, 8'hFF, 8'h80, 1'b0, 1'b0, 1'b0)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_PRELOAD, 16'h0000, 8'h00, 8'h7F, 1'b1,
			retired(8'd1, 1'b0, 3'd0, 8'h00, 1'b1, 8'h00, 8'h7F, 1'b0, 1'b0, 1'b0)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_ADDI, 3'd0, 3'd1, 6'h1F), 8'h00, 8'h00, 1'b1,
			retired(8'd2, 1'b1, 3'd1, 8'h1F, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_ADDI, 3'd0, 3'd1, 6'h20), 8'h00, 8'h00, 1'b1,
			retired(8'd3, 1'b1, 3'd1, 8'hE0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_ADDI, 3'd1, 3'd3, 6'h20), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			rtype(mm8_pkg::FN_ADD, 3'd3, 3'd3, 3'd4), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			rtype(mm8_pkg::FN_ADD, 3'd4, 3'd3, 3'd5), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			rtype(mm8_pkg::FN_SUB, 3'd0, 3'd4, 3'd6), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			rtype(mm8_pkg::FN_AND, 3'd1, 3'd3, 3'd7), 8'h00, 8'h00, 1'b0, '0));
		// Register zero is an ordinary register.
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			rtype(mm8_pkg::FN_OR, 3'd1, 3'd3, 3'd0), 8'h00, 8'h00, 1'b0, '0));
		// An unassigned funct and then an unassigned opcode hold the pc and write nothing.
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC, rtype(3'd7, 3'd0, 3'd0, 3'd0),
			8'h00, 8'h00, 1'b1,
			retired(8'd9, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC, 16'h1FFF, 8'h00, 8'h00, 1'b1,
			retired(8'd9, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_LW, 3'd2, 3'd5, 6'd0), 8'h00, 8'h00, 1'b1,
			retired(8'd10, 1'b1, 3'd5, 8'h7F, 1'b0, 8'h00, 8'h7F, 1'b0, 1'b0, 1'b0)));
		// A negative base wraps the store address into the top of the memory.
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_SW, 3'd1, 3'd7, 6'h20), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_LW, 3'd4, 3'd2, 6'h3F), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_BEQ, 3'd0, 3'd0, 6'h20), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_BEQ, 3'd1, 3'd3, 6'h05), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_BEQ, 3'd0, 3'd0, 6'h1F), 8'h00, 8'h00, 1'b0, '0));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_J, 3'd0, 3'd1, 6'h3F), 8'h00, 8'h00, 1'b1,
			retired(8'd128, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0)));
		// The bits above the jump address are ignored.
		directed_rows.push_back(stim_row(mm8_pkg::KIND_EXEC,
			itype(mm8_pkg::OP_J, 3'd7, 3'd6, 6'h00), 8'h00, 8'h00, 1'b1,
			retired(8'd1, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0)));
		directed_rows.push_back(stim_row(mm8_pkg::KIND_PRELOAD, 16'h1234, 8'h55, 8'hAA, 1'b0,
			'0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].paddr,
				directed_rows[i].pval, directed_rows[i].typed, directed_rows[i].want);
		end
		drain();

		send_random(700);

		// The sink holds off for a long stretch while items keep coming, so the core fills up.
		sender_idle_en = 1'b0;
		hold_request = 1'b1;
		send_random(60);
		sender_idle_en = 1'b1;
		drain();

		send_random(790);
		sender_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		send_random(250);
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		mm8_pkg::result_t got;
		mm8_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = mm8_pkg::result_t'(m_tdata);
			if (pending_retires.size() == 0) begin
				$error("result transfer with nothing outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_retires.pop_front();
				check_field("next_pc", want.next_pc, got.next_pc);
				check_field("reg_write", 8'(want.reg_write), 8'(got.reg_write));
				check_field("reg_index", 8'(want.reg_index), 8'(got.reg_index));
				check_field("reg_value", want.reg_value, got.reg_value);
				check_field("mem_write", 8'(want.mem_write), 8'(got.mem_write));
				check_field("mem_address", want.mem_address, got.mem_address);
				check_field("mem_value", want.mem_value, got.mem_value);
				check_field("overflow", 8'(want.overflow), 8'(got.overflow));
				check_field("branch_taken", 8'(want.branch_taken), 8'(got.branch_taken));
				check_field("illegal", 8'(want.illegal), 8'(got.illegal));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

// File: mini_mips8_single_cycle_core.f
hw/rtl/mm8_pkg.sv
hw/rtl/mm8_ram.sv
hw/rtl/mini_mips8_single_cycle_core.sv
tb/mini_mips8_single_cycle_core_test.sv
